>>> rtl/pool_allocator_exact_fit_reuse_defines.svh
// Assertion macros shared by the pool allocator RTL.
// Depends on: the using module having clk and rst_n in scope.
`ifndef POOL_ALLOCATOR_EXACT_FIT_REUSE_DEFINES_SVH
`define POOL_ALLOCATOR_EXACT_FIT_REUSE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define PAE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication
`define PAE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pae_pkg.sv
// Package for the pool allocator: field widths, codes, payload types.
// No dependencies.
package pae_pkg;

    localparam int ADDR_W  = 12;
    localparam int LEN_W   = 12;
    localparam int TOTAL_W = 12;

    localparam int POOL_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MAX_BLOCKS_DEF   = 64;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    typedef struct packed {
        logic              action;
        logic [LEN_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  block_address;
        logic [TOTAL_W-1:0] bytes_in_use;
    } rsp_t;

endpackage

>>> rtl/pae_ifs.sv
// Valid/ready channel interfaces for allocator requests and results.
// Depends on: pae_pkg.
interface pae_req_if;
    logic          valid;
    logic          ready;
    pae_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pae_rsp_if;
    logic          valid;
    logic          ready;
    pae_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/pae_table.sv
// Block table memory: one write port, one registered read port.
// Depends on: pae_pkg (length width).
module pae_table #(
    parameter int DEPTH  = pae_pkg::MAX_BLOCKS_DEF,
    parameter int OFFS_W = 12
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  logic [OFFS_W-1:0]        wr_offset,
    input  logic [pae_pkg::LEN_W-1:0] wr_length,
    input  logic                     wr_alloc,
    input  logic [$clog2(DEPTH)-1:0] wr_rank,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [OFFS_W-1:0]        rd_offset,
    output logic [pae_pkg::LEN_W-1:0] rd_length,
    output logic                     rd_alloc,
    output logic [$clog2(DEPTH)-1:0] rd_rank
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int WORD_W = OFFS_W + pae_pkg::LEN_W + 1 + IDX_W;

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [WORD_W-1:0] rd_word_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_idx] <= {wr_offset, wr_length, wr_alloc, wr_rank};
        end
        rd_word_reg <= mem_reg[rd_idx];
    end

    assign {rd_offset, rd_length, rd_alloc, rd_rank} = rd_word_reg;

endmodule

>>> rtl/pool_allocator_exact_fit_reuse.sv
// Pool allocator top level: bump allocation with exact-fit reuse of freed blocks.
// Depends on: pae_pkg, pae_ifs, pae_table, pool_allocator_exact_fit_reuse_defines.svh.
//
//  channel | dir | payload                                   | accepted when
//  --------+-----+-------------------------------------------+-------------------
//  req     | in  | action, request_bytes, free_address       | req.valid & ready
//  rsp     | out | status, block_address, bytes_in_use       | rsp.valid & ready
//
// A request walks the block table through the single table read port, one entry
// per cycle over the table entries in use (at most MAX_BLOCKS); when a freed block
// is reused, a second pass over the table renumbers the free order.
// One request at a time; req.ready is high only while the sequencer is idle.
// The result sits in an output register; a stalled rsp holds the sequencer
// in its final state. Reset is asynchronous; the table needs no clearing.
`include "pool_allocator_exact_fit_reuse_defines.svh"

module pool_allocator_exact_fit_reuse #(
    parameter int POOL_BYTES   = pae_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = pae_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = pae_pkg::MAX_BLOCKS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pae_req_if.sink      req,
    pae_rsp_if.source    rsp
);

    localparam int ADDR_W  = pae_pkg::ADDR_W;
    localparam int LEN_W   = pae_pkg::LEN_W;
    localparam int TOTAL_W = pae_pkg::TOTAL_W;
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int OFFS_W  = $clog2(POOL_BYTES);
    localparam int BUMP_W  = $clog2(POOL_BYTES + 1);
    localparam int NEED_W  = $clog2(POOL_BYTES + HEADER_BYTES + (1 << LEN_W));
    localparam int CMP_W   = (OFFS_W > ADDR_W) ? OFFS_W : ADDR_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FIND = 4'b0010,
        S_FIX  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]   free_count_reg, free_count_next;
    logic [BUMP_W-1:0]  bump_reg, bump_next;
    logic [TOTAL_W-1:0] in_use_reg, in_use_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               pv_reg, pv_next;
    logic               found_reg, found_next;
    logic               out_valid_reg, out_valid_next;

    // Request and scan payload
    logic                act_reg, act_next;
    logic [LEN_W-1:0]    size_reg, size_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]    best_rank_reg, best_rank_next;
    logic [OFFS_W-1:0]   best_ofs_reg, best_ofs_next;
    logic [LEN_W-1:0]    best_len_reg, best_len_next;
    pae_pkg::status_t    res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    pae_pkg::rsp_t       out_reg, out_next;

    // Table ports
    logic                tbl_wr_en;
    logic [IDX_W-1:0]    tbl_wr_idx;
    logic [OFFS_W-1:0]   tbl_wr_offset;
    logic [LEN_W-1:0]    tbl_wr_length;
    logic                tbl_wr_alloc;
    logic [IDX_W-1:0]    tbl_wr_rank;
    logic [OFFS_W-1:0]   rd_offset;
    logic [LEN_W-1:0]    rd_length;
    logic                rd_alloc;
    logic [IDX_W-1:0]    rd_rank;

    // Shared compare and add terms
    logic                issue;
    logic [NEED_W-1:0]   need;
    logic [NEED_W-1:0]   new_ofs;
    logic                fits;
    logic                table_full;
    logic                alloc_hit;
    logic                free_hit;

    pae_table #(
        .DEPTH  (MAX_BLOCKS),
        .OFFS_W (OFFS_W)
    ) u_table (
        .clk       (clk),
        .wr_en     (tbl_wr_en),
        .wr_idx    (tbl_wr_idx),
        .wr_offset (tbl_wr_offset),
        .wr_length (tbl_wr_length),
        .wr_alloc  (tbl_wr_alloc),
        .wr_rank   (tbl_wr_rank),
        .rd_idx    (rd_idx_reg[IDX_W-1:0]),
        .rd_offset (rd_offset),
        .rd_length (rd_length),
        .rd_alloc  (rd_alloc),
        .rd_rank   (rd_rank)
    );

    assign issue      = rd_idx_reg < entry_count_reg;
    assign new_ofs    = NEED_W'(bump_reg) + NEED_W'(HEADER_BYTES);
    assign need       = new_ofs + NEED_W'(size_reg);
    assign fits       = need <= NEED_W'(POOL_BYTES);
    assign table_full = entry_count_reg == CNT_W'(MAX_BLOCKS);

    // Oldest free block of exactly the requested size
    assign alloc_hit = pv_reg && !rd_alloc && (rd_length == size_reg)
                       && (!found_reg || (rd_rank < best_rank_reg));
    // First allocated block at the freed address
    assign free_hit  = pv_reg && rd_alloc && !found_reg
                       && (CMP_W'(rd_offset) == CMP_W'(addr_reg));

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        free_count_next  = free_count_reg;
        bump_next        = bump_reg;
        in_use_next      = in_use_reg;
        rd_idx_next      = rd_idx_reg;
        pv_next          = pv_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        act_next         = act_reg;
        size_next        = size_reg;
        addr_next        = addr_reg;
        pidx_next        = pidx_reg;
        best_idx_next    = best_idx_reg;
        best_rank_next   = best_rank_reg;
        best_ofs_next    = best_ofs_reg;
        best_len_next    = best_len_reg;
        res_status_next  = res_status_reg;
        res_addr_next    = res_addr_reg;
        out_next         = out_reg;
        tbl_wr_en        = 1'b0;
        tbl_wr_idx       = best_idx_reg;
        tbl_wr_offset    = rd_offset;
        tbl_wr_length    = rd_length;
        tbl_wr_alloc     = 1'b1;
        tbl_wr_rank      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next    = req.data.action;
                    size_next   = req.data.request_bytes;
                    addr_next   = req.data.free_address;
                    rd_idx_next = '0;
                    pv_next     = 1'b0;
                    found_next  = 1'b0;
                    if ((req.data.action == pae_pkg::ACT_ALLOC)
                        && (req.data.request_bytes == '0))
                    begin
                        res_status_next = pae_pkg::ST_BAD_SIZE;
                        res_addr_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIND;
                    end
                end
            end

            S_FIND:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                pv_next   = issue;
                pidx_next = rd_idx_reg[IDX_W-1:0];

                if ((act_reg == pae_pkg::ACT_ALLOC) && alloc_hit)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = pidx_reg;
                    best_rank_next = rd_rank;
                    best_ofs_next  = rd_offset;
                end
                if ((act_reg == pae_pkg::ACT_FREE) && free_hit)
                begin
                    found_next    = 1'b1;
                    best_idx_next = pidx_reg;
                    best_ofs_next = rd_offset;
                    best_len_next = rd_length;
                end

                // Whole table seen: decide
                if (!issue && !pv_reg)
                begin
                    res_addr_next = '0;
                    if (act_reg == pae_pkg::ACT_FREE)
                    begin
                        if (found_reg)
                        begin
                            tbl_wr_en       = 1'b1;
                            tbl_wr_idx      = best_idx_reg;
                            tbl_wr_offset   = best_ofs_reg;
                            tbl_wr_length   = best_len_reg;
                            tbl_wr_alloc    = 1'b0;
                            tbl_wr_rank     = IDX_W'(free_count_reg);
                            free_count_next = free_count_reg + CNT_W'(1);
                            in_use_next     = in_use_reg - TOTAL_W'(best_len_reg);
                            res_status_next = pae_pkg::ST_OK;
                        end
                        else
                        begin
                            res_status_next = pae_pkg::ST_NOT_ALLOC;
                        end
                        state_next = S_DONE;
                    end
                    else if (found_reg)
                    begin
                        rd_idx_next = '0;
                        pv_next     = 1'b0;
                        state_next  = S_FIX;
                    end
                    else if (!fits || table_full)
                    begin
                        res_status_next = pae_pkg::ST_NO_SPACE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        tbl_wr_en        = 1'b1;
                        tbl_wr_idx       = entry_count_reg[IDX_W-1:0];
                        tbl_wr_offset    = OFFS_W'(new_ofs);
                        tbl_wr_length    = size_reg;
                        tbl_wr_alloc     = 1'b1;
                        tbl_wr_rank      = '0;
                        entry_count_next = entry_count_reg + CNT_W'(1);
                        bump_next        = BUMP_W'(need);
                        in_use_next      = in_use_reg + TOTAL_W'(size_reg);
                        res_status_next  = pae_pkg::ST_OK;
                        res_addr_next    = ADDR_W'(new_ofs);
                        state_next       = S_DONE;
                    end
                end
            end

            S_FIX:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                pv_next   = issue;
                pidx_next = rd_idx_reg[IDX_W-1:0];

                // Reclaim the chosen block, close the gap in the free order
                if (pv_reg)
                begin
                    tbl_wr_idx = pidx_reg;
                    if (pidx_reg == best_idx_reg)
                    begin
                        tbl_wr_en    = 1'b1;
                        tbl_wr_alloc = 1'b1;
                        tbl_wr_rank  = '0;
                    end
                    else if (!rd_alloc && (rd_rank > best_rank_reg))
                    begin
                        tbl_wr_en    = 1'b1;
                        tbl_wr_alloc = 1'b0;
                        tbl_wr_rank  = rd_rank - IDX_W'(1);
                    end
                end

                if (!issue && !pv_reg)
                begin
                    if (free_count_reg != '0)
                    begin
                        free_count_next = free_count_reg - CNT_W'(1);
                    end
                    in_use_next     = in_use_reg + TOTAL_W'(size_reg);
                    res_status_next = pae_pkg::ST_OK;
                    res_addr_next   = ADDR_W'(best_ofs_reg);
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.status        = res_status_reg;
                    out_next.block_address = res_addr_reg;
                    out_next.bytes_in_use  = in_use_reg;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            free_count_reg  <= '0;
            bump_reg        <= '0;
            in_use_reg      <= '0;
            rd_idx_reg      <= '0;
            pv_reg          <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            free_count_reg  <= free_count_next;
            bump_reg        <= bump_next;
            in_use_reg      <= in_use_next;
            rd_idx_reg      <= rd_idx_next;
            pv_reg          <= pv_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        pidx_reg       <= pidx_next;
        best_idx_reg   <= best_idx_next;
        best_rank_reg  <= best_rank_next;
        best_ofs_reg   <= best_ofs_next;
        best_len_reg   <= best_len_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_reg        <= out_next;
    end

    // Checks
    `PAE_ASSERT_ALWAYS(a_free_le_entries, free_count_reg <= entry_count_reg, "free count exceeds table entries")
    `PAE_ASSERT_ALWAYS(a_bump_in_pool, int'(bump_reg) <= POOL_BYTES, "bump pointer beyond pool")
    `PAE_ASSERT_IMPLY(a_wr_in_scan, tbl_wr_en, (state_reg == S_FIND) || (state_reg == S_FIX), "table write outside a scan")
    `PAE_ASSERT_NEXT(a_accept_starts, req.valid && req.ready, (state_reg == S_FIND) || (state_reg == S_DONE), "accepted request did not start")
    `PAE_ASSERT_NEXT(a_count_grows, 1'b1, entry_count_reg >= $past(entry_count_reg), "table entry count shrank")

endmodule
